// File: design/aarm_pkg.sv
// Shared types, widths, constants and the arctangent table for the rotation matrix block.
package aarm_pkg;

  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int TABLE_LEN = 24;

  localparam int ANGLE_W = 24;
  localparam int AXIS_W  = 16;
  localparam int ENTRY_W = 20;
  localparam int XY_W    = 33;   // Q30 with headroom for CORDIC growth
  localparam int Z_W     = 26;   // residual angle, degrees * 2^16
  localparam int CS_W    = 18;   // cos/sin in Q14
  localparam int PP_W    = 2 * AXIS_W;
  localparam int PS_W    = CS_W + AXIS_W;
  localparam int ACC_W   = 48;   // Q42 entry accumulator
  localparam int LOW_W   = 11;   // a full turn is 45 blocks of 2^11 units
  localparam int U_W     = 14;
  localparam int Q_W     = 8;
  localparam int REM_W   = 17;

  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int TURN_BLOCKS  = 45;
  localparam int TURN_BIAS    = 4140;   // 92 full turns in blocks, makes the block count positive
  localparam int RECIP        = 5826;   // ceil(2^18 / 45)
  localparam int RECIP_SHIFT  = 18;
  localparam int RECIP_W      = 13;
  localparam int ANGLE_SHIFT  = 8;      // 1/256 degree -> degrees * 2^16
  localparam int CS_SHIFT     = 16;     // Q30 -> Q14
  localparam int ONE_SHIFT    = 28;     // c * I term in Q42
  localparam int CROSS_SHIFT  = 14;     // s * [a]x term in Q42
  localparam int ONE_Q14      = 16384;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [XY_W-1:0]    xy_t;
  typedef logic signed [Z_W-1:0]     z_t;
  typedef logic signed [CS_W-1:0]    cs_t;
  typedef logic signed [PP_W-1:0]    pp_t;
  typedef logic signed [PS_W-1:0]    ps_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [REM_W:0]     turn_t;

  localparam xy_t  GAIN_Q30  = xy_t'(652032874);
  localparam xy_t  ROUND_Q16 = xy_t'(32768);
  localparam acc_t ROUND_Q28 = acc_t'(134217728);
  localparam acc_t ENTRY_MAX = acc_t'(524287);
  localparam acc_t ENTRY_MIN = acc_t'(-524288);

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } axis_vec_t;

  typedef struct packed {
    xy_t       x;
    xy_t       y;
    z_t        z;
    logic      neg;
    axis_vec_t axis;
  } cordic_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  localparam logic [22:0] ATAN_TABLE [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

endpackage

// File: design/aarm_if.sv
// Valid/ready channel interfaces for the input item and the result matrix.
interface aarm_item_if;
  logic               valid;
  logic               ready;
  aarm_pkg::angle_t   angle_deg;
  aarm_pkg::axis_t    axis_x;
  aarm_pkg::axis_t    axis_y;
  aarm_pkg::axis_t    axis_z;

  modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
  modport sink   (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_result_if;
  logic               valid;
  logic               ready;
  aarm_pkg::entry_t   m00;
  aarm_pkg::entry_t   m01;
  aarm_pkg::entry_t   m02;
  aarm_pkg::entry_t   m10;
  aarm_pkg::entry_t   m11;
  aarm_pkg::entry_t   m12;
  aarm_pkg::entry_t   m20;
  aarm_pkg::entry_t   m21;
  aarm_pkg::entry_t   m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

// File: design/aarm_reduce.sv
// Two-stage angle reduction: modulo 360 degrees, fold into [-90,90], CORDIC seed.
module aarm_reduce (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  aarm_pkg::angle_t    angle,
  input  aarm_pkg::axis_vec_t axis,
  output logic                out_valid,
  output aarm_pkg::cordic_t   out_d
);

  localparam int H_W = aarm_pkg::ANGLE_W - aarm_pkg::LOW_W;

  // stage 1: block count modulo 45 via reciprocal multiply
  logic signed [H_W-1:0]                 h;
  logic signed [aarm_pkg::U_W:0]         u_s;
  logic [aarm_pkg::U_W-1:0]              u;
  logic [aarm_pkg::U_W+aarm_pkg::RECIP_W-1:0] prod;

  logic                                  v1;
  logic [aarm_pkg::U_W-1:0]              u1;
  logic [aarm_pkg::Q_W-1:0]              q1;
  logic [aarm_pkg::LOW_W-1:0]            low1;
  aarm_pkg::axis_vec_t                   axis1;

  assign h    = angle[aarm_pkg::ANGLE_W-1:aarm_pkg::LOW_W];
  assign u_s  = (aarm_pkg::U_W+1)'(h) + (aarm_pkg::U_W+1)'(aarm_pkg::TURN_BIAS);
  assign u    = u_s[aarm_pkg::U_W-1:0];
  assign prod = (aarm_pkg::U_W+aarm_pkg::RECIP_W)'(u)
              * (aarm_pkg::U_W+aarm_pkg::RECIP_W)'(aarm_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1    <= u;
      q1    <= prod[aarm_pkg::RECIP_SHIFT +: aarm_pkg::Q_W];
      low1  <= angle[aarm_pkg::LOW_W-1:0];
      axis1 <= axis;
    end
  end

  // stage 2: remainder, fold, seed
  logic [aarm_pkg::U_W-1:0]   qx;
  logic [aarm_pkg::U_W-1:0]   m;
  logic [aarm_pkg::REM_W-1:0] rem;
  aarm_pkg::turn_t            rr0, rr1, rr2;
  logic                       neg;
  aarm_pkg::cordic_t          seed;

  assign qx  = aarm_pkg::U_W'(q1) * aarm_pkg::U_W'(aarm_pkg::TURN_BLOCKS);
  assign m   = u1 - qx;
  assign rem = {m[aarm_pkg::REM_W-aarm_pkg::LOW_W-1:0], low1};

  always_comb begin
    rr0 = aarm_pkg::turn_t'({1'b0, rem});
    if (rr0 > aarm_pkg::HALF_TURN) begin
      rr1 = aarm_pkg::turn_t'(rr0 - aarm_pkg::FULL_TURN);
    end else begin
      rr1 = rr0;
    end
    neg = 1'b0;
    rr2 = rr1;
    if (rr1 > aarm_pkg::QUARTER_TURN) begin
      rr2 = aarm_pkg::turn_t'(rr1 - aarm_pkg::HALF_TURN);
      neg = 1'b1;
    end else if (rr1 < -aarm_pkg::QUARTER_TURN) begin
      rr2 = aarm_pkg::turn_t'(rr1 + aarm_pkg::HALF_TURN);
      neg = 1'b1;
    end
    seed.x    = aarm_pkg::GAIN_Q30;
    seed.y    = '0;
    seed.z    = aarm_pkg::z_t'(rr2) <<< aarm_pkg::ANGLE_SHIFT;
    seed.neg  = neg;
    seed.axis = axis1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= seed;
    end
  end

endmodule

// File: design/aarm_cell.sv
// One CORDIC rotation cell: a single micro-rotation by atan(2^-IDX), registered.
module aarm_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  aarm_pkg::cordic_t in_d,
  output logic              out_valid,
  output aarm_pkg::cordic_t out_d
);

  localparam aarm_pkg::z_t ATAN = aarm_pkg::z_t'(aarm_pkg::ATAN_TABLE[IDX]);

  aarm_pkg::xy_t     x, y, dx, dy;
  aarm_pkg::z_t      z;
  aarm_pkg::cordic_t nxt;

  assign x  = in_d.x;
  assign y  = in_d.y;
  assign z  = in_d.z;
  assign dx = y >>> IDX;
  assign dy = x >>> IDX;

  always_comb begin
    nxt = in_d;
    if (!z[aarm_pkg::Z_W-1]) begin
      nxt.x = x - dx;
      nxt.y = y + dy;
      nxt.z = z - ATAN;
    end else begin
      nxt.x = x + dx;
      nxt.y = y - dy;
      nxt.z = z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d <= nxt;
    end
  end

endmodule

// File: design/aarm_matrix.sv
// Rodrigues assembly: cos/sin rounding, products, Q42 accumulation, rounding and clamp.
module aarm_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  aarm_pkg::cordic_t in_d,
  output logic              out_valid,
  output aarm_pkg::entry_t  m [3][3]
);

  // stage P: undo the half-turn fold and round Q30 -> Q14
  aarm_pkg::xy_t       xn, yn, xr, yr;
  logic                vp;
  aarm_pkg::cs_t       cp, sp;
  aarm_pkg::axis_vec_t axp;

  assign xn = in_d.neg ? -in_d.x : in_d.x;
  assign yn = in_d.neg ? -in_d.y : in_d.y;
  assign xr = xn + aarm_pkg::ROUND_Q16;
  assign yr = yn + aarm_pkg::ROUND_Q16;

  always_ff @(posedge clk) begin
    if (adv) begin
      cp  <= aarm_pkg::cs_t'(xr >>> aarm_pkg::CS_SHIFT);
      sp  <= aarm_pkg::cs_t'(yr >>> aarm_pkg::CS_SHIFT);
      axp <= in_d.axis;
    end
  end

  // stage 1: axis outer product, s * axis, 1 - c
  aarm_pkg::axis_t a [3];
  logic            v1;
  aarm_pkg::pp_t   pp1 [3][3];
  aarm_pkg::ps_t   ps1 [3];
  aarm_pkg::cs_t   d1, c1;

  assign a[0] = axp.x;
  assign a[1] = axp.y;
  assign a[2] = axp.z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          pp1[r][k] <= a[r] * a[k];
        end
        ps1[r] <= sp * a[r];
      end
      d1 <= aarm_pkg::cs_t'(aarm_pkg::ONE_Q14 - cp);
      c1 <= cp;
    end
  end

  // stage 2: (1 - c) * ai * aj, plus the identity and cross-product terms
  logic                                      v2;
  logic signed [aarm_pkg::CS_W+aarm_pkg::PP_W-1:0] full [3][3];
  aarm_pkg::acc_t                            extra [3][3];
  aarm_pkg::acc_t                            prod2 [3][3];
  aarm_pkg::acc_t                            extra2 [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        full[r][k]  = d1 * pp1[r][k];
        extra[r][k] = '0;
        if (r == k) begin
          extra[r][k] = aarm_pkg::acc_t'(c1) <<< aarm_pkg::ONE_SHIFT;
        end else if (r == 0 && k == 1) begin
          extra[r][k] = -(aarm_pkg::acc_t'(ps1[2]) <<< aarm_pkg::CROSS_SHIFT);
        end else if (r == 0 && k == 2) begin
          extra[r][k] = aarm_pkg::acc_t'(ps1[1]) <<< aarm_pkg::CROSS_SHIFT;
        end else if (r == 1 && k == 0) begin
          extra[r][k] = aarm_pkg::acc_t'(ps1[2]) <<< aarm_pkg::CROSS_SHIFT;
        end else if (r == 1 && k == 2) begin
          extra[r][k] = -(aarm_pkg::acc_t'(ps1[0]) <<< aarm_pkg::CROSS_SHIFT);
        end else if (r == 2 && k == 0) begin
          extra[r][k] = -(aarm_pkg::acc_t'(ps1[1]) <<< aarm_pkg::CROSS_SHIFT);
        end else begin
          extra[r][k] = aarm_pkg::acc_t'(ps1[0]) <<< aarm_pkg::CROSS_SHIFT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod2[r][k]  <= aarm_pkg::acc_t'(full[r][k]);
          extra2[r][k] <= extra[r][k];
        end
      end
    end
  end

  // stage 3: sum, round Q42 -> Q14, clamp to the entry range
  aarm_pkg::acc_t sh [3][3];
  aarm_pkg::entry_t sat [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        sh[r][k] = (prod2[r][k] + extra2[r][k] + aarm_pkg::ROUND_Q28) >>> aarm_pkg::ONE_SHIFT;
        if (sh[r][k] > aarm_pkg::ENTRY_MAX) begin
          sat[r][k] = aarm_pkg::entry_t'(aarm_pkg::ENTRY_MAX);
        end else if (sh[r][k] < aarm_pkg::ENTRY_MIN) begin
          sat[r][k] = aarm_pkg::entry_t'(aarm_pkg::ENTRY_MIN);
        end else begin
          sat[r][k] = sh[r][k][aarm_pkg::ENTRY_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vp        <= in_valid;
      v1        <= vp;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// File: design/axis_angle_rotation_matrix.sv
// Top level: axis-angle to 3x3 rotation matrix, angle reduction, CORDIC cell chain, assembly.
//
// Takes an angle (signed, 1/256 degree units) and an axis (three signed Q2.14
// components, used as given, not normalized) and returns the nine entries of
// R = c*I + (1-c)*a*aT + s*[a]x as signed Q6.14. The angle is reduced modulo
// 360 degrees and folded into [-90,90] degrees; cos and sin then come from a
// chain of CORDIC_STEPS rotation cells (8..24, table length caps it at 24),
// each cell doing one micro-rotation and passing its x/y/z word to the next
// on every enabled cycle. The whole path is a stall-together pipeline of
// CORDIC_STEPS + 6 register stages (2 reduction stages, one cell per step,
// 4 assembly stages, the last being the output register): one transfer can
// be accepted every clock while the sink does not stall the output.
// When the result is held by the sink, every stage holds and item.ready drops;
// item.ready is high whenever the output register is empty or being taken.
// There is no configuration and no state between items; reset only clears
// the valid bits of the stages.
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  aarm_item_if.sink     item,
  aarm_result_if.source result
);

  localparam int STEPS = (CORDIC_STEPS > aarm_pkg::TABLE_LEN) ? aarm_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;

  // Single pipeline enable: advance when the output slot is free or draining.
  logic adv;
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  aarm_pkg::axis_vec_t axis_in;
  assign axis_in.x = item.axis_x;
  assign axis_in.y = item.axis_y;
  assign axis_in.z = item.axis_z;

  logic              chain_v [STEPS+1];
  aarm_pkg::cordic_t chain_d [STEPS+1];

  aarm_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (item.valid),
    .angle     (item.angle_deg),
    .axis      (axis_in),
    .out_valid (chain_v[0]),
    .out_d     (chain_d[0])
  );

  // CORDIC: cell i rotates by atan(2^-i)
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    aarm_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_v[i]),
      .in_d      (chain_d[i]),
      .out_valid (chain_v[i+1]),
      .out_d     (chain_d[i+1])
    );
  end

  aarm_pkg::entry_t m [3][3];

  aarm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (chain_v[STEPS]),
    .in_d      (chain_d[STEPS]),
    .out_valid (result.valid),
    .m         (m)
  );

  assign result.m00 = m[0][0];
  assign result.m01 = m[0][1];
  assign result.m02 = m[0][2];
  assign result.m10 = m[1][0];
  assign result.m11 = m[1][1];
  assign result.m12 = m[1][2];
  assign result.m20 = m[2][0];
  assign result.m21 = m[2][1];
  assign result.m22 = m[2][2];

endmodule

// File: tb/sv/tb_axis_angle_rotation_matrix.sv
`timescale 1ns / 1ps
// Self-checking testbench for the axis-angle rotation matrix block.
module tb_axis_angle_rotation_matrix;

  // Run sizing and block latency
  localparam int STEPS        = aarm_pkg::CORDIC_STEPS_DEFAULT;
  localparam int PIPE_LATENCY = STEPS + 6;      // register stages, input to output register
  localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
  localparam int HOLD_LEN     = 300;            // long output stall, in cycles
  localparam int CYCLE_LIMIT  = 200000;

  // Angle units: 1/256 degree
  localparam longint TURN_UNITS    = 92160;
  localparam longint HALF_UNITS    = 46080;
  localparam longint QUARTER_UNITS = 23040;
  localparam longint UNIT_Q14      = 16384;
  localparam longint K_GAIN_Q30    = 652032874;
  localparam longint ENTRY_HI      = 524287;
  localparam longint ENTRY_LO      = -524288;
  localparam int     ATAN_LEN      = 24;

  // atan(2^-i) in degrees * 2^16
  localparam longint ATAN_DEG16 [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    aarm_pkg::entry_t m00;
    aarm_pkg::entry_t m01;
    aarm_pkg::entry_t m02;
    aarm_pkg::entry_t m10;
    aarm_pkg::entry_t m11;
    aarm_pkg::entry_t m12;
    aarm_pkg::entry_t m20;
    aarm_pkg::entry_t m21;
    aarm_pkg::entry_t m22;
  } matrix_t;

  logic clk;
  logic rst;

  aarm_item_if   item_ch ();
  aarm_result_if result_ch ();

  axis_angle_rotation_matrix #(
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  // Matrices still owed by the block, oldest first
  matrix_t pending_matrices [$];

  int  mismatch_count = 0;
  int  items_sent;
  int  matrices_seen = 0;
  int  cycle_count;
  bit  src_idle;                 // sender may insert gaps
  bit  sink_idle;                // receiver may drop ready at random
  int  hold_requests;            // bumped by a test to request a long stall
  int  hold_served = 0;          // owned by the receiver process
  int  hold_cnt = 0;

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: Rodrigues matrix with fixed-step CORDIC cos/sin.
  // Angle is reduced mod 360 deg into (-180,180], then folded into [-90,90];
  // a fold negates cos and sin afterwards. All math in 64 bits, so nothing
  // here overflows; entries are rounded half up from Q42 and clamped.
  // --------------------------------------------------------------------------
  function automatic matrix_t rodrigues_matrix(aarm_pkg::angle_t ang, aarm_pkg::axis_t ax,
                                               aarm_pkg::axis_t ay, aarm_pkg::axis_t az);
    longint r, x, y, z, dx, dy, c, s, acc, n;
    longint a [3];
    bit     flip;
    int     steps;
    aarm_pkg::entry_t e [9];
    r    = ang;
    a[0] = ax;
    a[1] = ay;
    a[2] = az;
    flip = 1'b0;
    // % truncates toward zero, so negatives need the extra turn
    r = r % TURN_UNITS;
    if (r < 0) r += TURN_UNITS;
    if (r > HALF_UNITS) r -= TURN_UNITS;
    if (r > QUARTER_UNITS) begin
      r -= HALF_UNITS;
      flip = 1'b1;
    end else if (r < -QUARTER_UNITS) begin
      r += HALF_UNITS;
      flip = 1'b1;
    end
    z = r * 256;
    x = K_GAIN_Q30;
    y = 0;
    steps = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG16[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_DEG16[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 32768) >>> 16;
    s = (y + 32768) >>> 16;
    for (int row = 0; row < 3; row++) begin
      for (int col = 0; col < 3; col++) begin
        // cross-product matrix entry
        n = 0;
        if (row == 0 && col == 1) n = -a[2];
        if (row == 0 && col == 2) n = a[1];
        if (row == 1 && col == 0) n = a[2];
        if (row == 1 && col == 2) n = -a[0];
        if (row == 2 && col == 0) n = -a[1];
        if (row == 2 && col == 1) n = a[0];
        acc = (UNIT_Q14 - c) * (a[row] * a[col]);
        if (row == col) acc += c * (longint'(1) << 28);
        acc += s * n * UNIT_Q14;
        acc = (acc + (longint'(1) << 27)) >>> 28;
        if (acc > ENTRY_HI) acc = ENTRY_HI;
        if (acc < ENTRY_LO) acc = ENTRY_LO;
        e[row * 3 + col] = aarm_pkg::entry_t'(acc);
      end
    end
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  function automatic void check_entry(string name, aarm_pkg::entry_t exp_v,
                                      aarm_pkg::entry_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: checks every result transfer against the oldest prediction and
  // drives result.ready for the next edge (one NBA per step).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    matrix_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      matrices_seen++;
      if (pending_matrices.size() == 0) begin
        $error("result transfer with no matrix pending");
        mismatch_count++;
      end else begin
        want = pending_matrices.pop_front();
        check_entry("m00", want.m00, result_ch.m00);
        check_entry("m01", want.m01, result_ch.m01);
        check_entry("m02", want.m02, result_ch.m02);
        check_entry("m10", want.m10, result_ch.m10);
        check_entry("m11", want.m11, result_ch.m11);
        check_entry("m12", want.m12, result_ch.m12);
        check_entry("m20", want.m20, result_ch.m20);
        check_entry("m21", want.m21, result_ch.m21);
        check_entry("m22", want.m22, result_ch.m22);
      end
    end
    // long stall on request, else random ~30% idle when enabled
    if (hold_cnt > 0) begin
      result_ch.ready <= 1'b0;
      hold_cnt        <= hold_cnt - 1;
    end else if (hold_served != hold_requests) begin
      result_ch.ready <= 1'b0;
      hold_cnt        <= HOLD_LEN;
      hold_served     <= hold_requests;
    end else begin
      result_ch.ready <= !sink_idle || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: one transfer per call. valid is only lowered during a gap, so a
  // back-to-back item keeps valid high with no second NBA in the same step.
  // --------------------------------------------------------------------------
  task automatic send_item(aarm_pkg::angle_t ang, aarm_pkg::axis_t ax,
                           aarm_pkg::axis_t ay, aarm_pkg::axis_t az);
    while (src_idle && $urandom_range(99) < 30) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.angle_deg <= ang;
    item_ch.axis_x    <= ax;
    item_ch.axis_y    <= ay;
    item_ch.axis_z    <= az;
    do @(posedge clk); while (!item_ch.ready);
    pending_matrices.push_back(rodrigues_matrix(ang, ax, ay, az));
    items_sent++;
  endtask

  // Directed item from plain integers, sized to the field widths
  task automatic send_directed(int ang, int ax, int ay, int az);
    send_item(aarm_pkg::angle_t'(ang), aarm_pkg::axis_t'(ax), aarm_pkg::axis_t'(ay),
              aarm_pkg::axis_t'(az));
  endtask

  // Sender pause: wait until every matrix is back, plus the pipe depth
  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mix of full-range angles, a few turns around zero, quarter-turn edges and angles within 128 degrees
  function automatic aarm_pkg::angle_t pick_angle();
    int k;
    case ($urandom_range(3))
      0: return aarm_pkg::angle_t'($urandom);
      1: return aarm_pkg::angle_t'(int'($urandom_range(4 * TURN_UNITS)) - 2 * int'(TURN_UNITS));
      2: begin
        k = int'($urandom_range(16)) - 8;
        return aarm_pkg::angle_t'(k * int'(QUARTER_UNITS) + int'($urandom_range(4)) - 2);
      end
      default: return aarm_pkg::angle_t'(int'($urandom_range(65535)) - 32768);
    endcase
  endfunction

  // Full-range, near-unit, small, or extreme axis components
  function automatic aarm_pkg::axis_t pick_axis_comp();
    int v;
    case ($urandom_range(3))
      0: return aarm_pkg::axis_t'($urandom);
      1: begin
        v = int'($urandom_range(256)) - 128;
        return aarm_pkg::axis_t'(($urandom_range(1) ? 16384 : -16384) + v);
      end
      2: return aarm_pkg::axis_t'(int'($urandom_range(128)) - 64);
      default: begin
        v = int'($urandom_range(2));
        return (v == 0) ? aarm_pkg::axis_t'(0) :
               (v == 1) ? aarm_pkg::axis_t'(32767) : aarm_pkg::axis_t'(-32768);
      end
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_item(pick_angle(), pick_axis_comp(), pick_axis_comp(), pick_axis_comp());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Quarter/half/full turn edges, fold boundaries, field extremes, zero and
  // extreme axes, angles far outside one turn.
  task automatic test_directed();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_directed(0,        16384,  0,      0);
    send_directed(23040,    0,      0,      16384);
    send_directed(-23040,   0,      16384,  0);
    send_directed(23041,    16384,  0,      0);
    send_directed(-23041,   0,      0,      16384);
    send_directed(46080,    16384,  0,      0);
    send_directed(-46080,   0,      16384,  0);
    send_directed(46081,    0,      0,      16384);
    send_directed(92160,    16384,  16384,  16384);
    send_directed(92159,    -16384, 0,      0);
    send_directed(69120,    0,      -16384, 0);
    send_directed(69121,    9459,   9459,   -9459);
    send_directed(8388607,  32767,  32767,  32767);
    send_directed(-8388608, -32768, -32768, -32768);
    send_directed(11520,    32767,  -32768, 0);
    send_directed(-11520,   0,      32767,  -32768);
    send_directed(7680,     0,      0,      0);
    send_directed(0,        -32768, -32768, -32768);
    send_directed(46080,    -32768, 32767,  -32768);
    send_directed(1,        9459,   -9459,  9459);
    send_directed(-1,       16384,  0,      0);
    wait_drain();
  endtask

  // Random items with both sides idling at random
  task automatic test_random_traffic(int count);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_random(count);
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // transfers; pipe fills and item.ready must drop without losing data.
  task automatic test_backpressure();
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    hold_requests <= hold_requests + 1;
    send_random(80);
    wait_drain();
  endtask

  // One transfer per clock on both sides
  task automatic test_streaming();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_random(100);
    wait_drain();
  endtask

  initial begin
    rst               = 1'b1;
    items_sent        = 0;
    hold_requests     = 0;
    src_idle          = 1'b0;
    sink_idle         = 1'b0;
    item_ch.valid     <= 1'b0;
    item_ch.angle_deg <= '0;
    item_ch.axis_x    <= '0;
    item_ch.axis_y    <= '0;
    item_ch.axis_z    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(250);
    test_backpressure();
    test_streaming();
    test_random_traffic(60);

    $display("Covered %0d input transfers and %0d checked matrices: turn edges, folds,",
             items_sent, matrices_seen);
    $display("extreme axes, random gaps on both sides, a long output stall and full-rate streaming.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
